[design/circle_distance_field_pixel_assert.svh]
// ----------------------------------------------------------------------------
// circle_distance_field_pixel assertion macros
// Shared property forms for the port checker; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_DISTANCE_FIELD_PIXEL_ASSERT_SVH
`define CIRCLE_DISTANCE_FIELD_PIXEL_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CDF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdf: implication check failed");

// condition holds at every edge out of reset
`define CDF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cdf: invariant check failed");

`endif

[design/cdf_pkg.sv]
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared constants, register codes and helpers for the circle distance field.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_SIZE  = 512;
  localparam int SIZE_W    = 10;
  localparam int PIX_W     = 9;
  localparam int COORD_W   = 18;
  localparam int RAD_W     = 17;
  localparam int DATA_W    = 18;
  localparam int IDX_W     = 3;
  localparam int LATENCY   = 16;

  localparam logic [COORD_W-1:0] CENTER_X_RST = 18'd26214;
  localparam logic [COORD_W-1:0] CENTER_Y_RST = 18'd32768;
  localparam logic [RAD_W-1:0]   RADIUS_RST   = 17'd21627;
  localparam logic [SIZE_W-1:0]  SIZE_RST     = 10'd32;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_TEX_WIDTH  = 3'd3,
    REG_TEX_HEIGHT = 3'd4
  } cfg_reg_t;

  // zero counts as one, oversize saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_SIZE)) begin
      r = SIZE_W'(MAX_SIZE);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

[design/cdf_div.sv]
// ----------------------------------------------------------------------------
// cdf_div
// Pipelined restoring divider: q = floor((2p+1) * 2^(F-1) / w), F quotient bits.
// ----------------------------------------------------------------------------
module cdf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [cdf_pkg::PIX_W-1:0]        num_p,
  input  logic [cdf_pkg::SIZE_W-1:0]       den,
  output logic                             out_vld,
  output logic [cdf_pkg::FRAC_BITS-1:0]    quo
);

  localparam int STEPS  = cdf_pkg::FRAC_BITS;
  localparam int STAGES = 4;
  localparam int PER    = (STEPS + STAGES - 1) / STAGES;
  localparam int REM_W  = cdf_pkg::SIZE_W + 1;

  logic [REM_W-1:0] rem_r [0:STAGES];
  logic [STEPS-1:0] quo_r [0:STAGES];
  logic             vld_r [0:STAGES];
  logic [REM_W-1:0] rem_nxt [1:STAGES];
  logic [STEPS-1:0] quo_nxt [1:STAGES];

  // p < w, so the first remainder is p; only the first fed bit is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0] <= REM_W'(num_p);
    quo_r[0] <= '0;
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    always_comb begin
      logic [REM_W-1:0] r;
      logic [STEPS-1:0] q;
      logic             ge;
      r = rem_r[s-1];
      q = quo_r[s-1];
      for (int j = 0; j < PER; j++) begin
        if ((s - 1) * PER + j < STEPS) begin
          r  = {r[REM_W-2:0], ((s - 1) * PER + j) == 0};
          ge = (r >= {1'b0, den});
          if (ge) begin
            r = r - {1'b0, den};
          end
          q = {q[STEPS-2:0], ge};
        end
      end
      rem_nxt[s] = r;
      quo_nxt[s] = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign out_vld = vld_r[STAGES];
  assign quo     = quo_r[STAGES];

endmodule

[design/cdf_sqrt.sv]
// ----------------------------------------------------------------------------
// cdf_sqrt
// Pipelined digit-by-digit integer square root, floor(sqrt(v)), 4 digits/stage.
// ----------------------------------------------------------------------------
module cdf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [39:0] val,
  output logic        out_vld,
  output logic [19:0] root
);

  localparam int VAL_W  = 40;
  localparam int ROOT_W = VAL_W / 2;
  localparam int STAGES = 5;
  localparam int PER    = ROOT_W / STAGES;
  localparam int REM_W  = ROOT_W + 3;

  logic [VAL_W-1:0]  val_r  [0:STAGES];
  logic [REM_W-1:0]  rem_r  [0:STAGES];
  logic [ROOT_W-1:0] root_r [0:STAGES];
  logic              vld_r  [0:STAGES];
  logic [VAL_W-1:0]  val_nxt  [1:STAGES];
  logic [REM_W-1:0]  rem_nxt  [1:STAGES];
  logic [ROOT_W-1:0] root_nxt [1:STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    val_r[0]  <= val;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    always_comb begin
      logic [VAL_W-1:0]  v;
      logic [REM_W-1:0]  r;
      logic [ROOT_W-1:0] q;
      logic [REM_W-1:0]  trial;
      logic              ge;
      v = val_r[s-1];
      r = rem_r[s-1];
      q = root_r[s-1];
      for (int j = 0; j < PER; j++) begin
        // remainder stays at or below twice the partial root
        r     = {r[REM_W-3:0], v[VAL_W-1:VAL_W-2]};
        v     = {v[VAL_W-3:0], 2'b00};
        trial = {1'b0, q, 2'b01};
        ge    = (r >= trial);
        if (ge) begin
          r = r - trial;
        end
        q = {q[ROOT_W-2:0], ge};
      end
      val_nxt[s]  = v;
      rem_nxt[s]  = r;
      root_nxt[s] = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_r[s-1];
      end
      val_r[s]  <= val_nxt[s];
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
    end
  end

  assign out_vld = vld_r[STAGES];
  assign root    = root_r[STAGES];

endmodule

[design/circle_distance_field_pixel.sv]
// ----------------------------------------------------------------------------
// circle_distance_field_pixel
// Grey level of one texel of a circle's signed distance field, one per clock.
// ----------------------------------------------------------------------------
// Path: dividers, abs deltas, squares, square root, signed distance, scale, output.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Most depth comes from the 4-stage sample divider and the 5-stage square root.
// Reset (rst_n low, synchronous) clears all valid bits and loads the default
// circle: center (26214, 32768), radius 21627, 32 x 32 texture.
module circle_distance_field_pixel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cdf_pkg::PIX_W-1:0]     in_pixel_x,
  input  logic [cdf_pkg::PIX_W-1:0]     in_pixel_y,
  output logic                          out_valid,
  output logic [7:0]                    out_intensity,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdf_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cdf_pkg::DATA_W-1:0]    cfg_data
);

  localparam int F = cdf_pkg::FRAC_BITS;

  logic [cdf_pkg::COORD_W-1:0] center_x_r, center_y_r;
  logic [cdf_pkg::RAD_W-1:0]   radius_r;
  logic [cdf_pkg::SIZE_W-1:0]  tex_width_r, tex_height_r;
  logic [cdf_pkg::SIZE_W-1:0]  w_eff, h_eff, m_eff;
  logic [cdf_pkg::PIX_W-1:0]   px_sat, py_sat;
  logic                        accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= cdf_pkg::CENTER_X_RST;
      center_y_r   <= cdf_pkg::CENTER_Y_RST;
      radius_r     <= cdf_pkg::RADIUS_RST;
      tex_width_r  <= cdf_pkg::SIZE_RST;
      tex_height_r <= cdf_pkg::SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cdf_pkg::cfg_reg_t'(cfg_index))
        cdf_pkg::REG_CENTER_X:   center_x_r   <= cfg_data;
        cdf_pkg::REG_CENTER_Y:   center_y_r   <= cfg_data;
        cdf_pkg::REG_RADIUS:     radius_r     <= cfg_data[cdf_pkg::RAD_W-1:0];
        cdf_pkg::REG_TEX_WIDTH:  tex_width_r  <= cfg_data[cdf_pkg::SIZE_W-1:0];
        cdf_pkg::REG_TEX_HEIGHT: tex_height_r <= cfg_data[cdf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = cdf_pkg::eff_size(tex_width_r);
  assign h_eff = cdf_pkg::eff_size(tex_height_r);
  assign m_eff = (w_eff > h_eff) ? w_eff : h_eff;

  // pixels past the edge clamp to the last column / row
  assign px_sat = ({1'b0, in_pixel_x} >= w_eff) ? cdf_pkg::PIX_W'(w_eff - 1'b1) : in_pixel_x;
  assign py_sat = ({1'b0, in_pixel_y} >= h_eff) ? cdf_pkg::PIX_W'(h_eff - 1'b1) : in_pixel_y;

  logic         sx_vld, sy_vld;
  logic [F-1:0] sx, sy;

  cdf_div u_div_x (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .num_p(px_sat), .den(w_eff),
    .out_vld(sx_vld), .quo(sx)
  );

  cdf_div u_div_y (
    .clk(clk), .rst_n(rst_n), .in_vld(accept), .num_p(py_sat), .den(h_eff),
    .out_vld(sy_vld), .quo(sy)
  );

  // absolute deltas
  logic signed [18:0] dx, dy;
  logic [17:0]        ax_r, ay_r, ax_nxt, ay_nxt;
  logic               abs_vld_r;

  assign dx = $signed({3'b000, sx}) - $signed({center_x_r[17], center_x_r});
  assign dy = $signed({3'b000, sy}) - $signed({center_y_r[17], center_y_r});
  assign ax_nxt = dx[18] ? 18'(-dx) : dx[17:0];
  assign ay_nxt = dy[18] ? 18'(-dy) : dy[17:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_vld_r <= 1'b0;
    end else begin
      abs_vld_r <= sx_vld & sy_vld;
    end
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
  end

  // squares
  logic [35:0] sqx_r, sqy_r;
  logic        sq_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else begin
      sq_vld_r <= abs_vld_r;
    end
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
  end

  logic [39:0] sum_sq;
  logic        dist_vld;
  logic [19:0] root_dist;

  assign sum_sq = 40'(sqx_r) + 40'(sqy_r);

  cdf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_vld(sq_vld_r), .val(sum_sq),
    .out_vld(dist_vld), .root(root_dist)
  );

  // signed distance, then scale by the larger size
  logic signed [20:0] sd_r;
  logic signed [31:0] scaled_r;
  logic               sd_vld_r, sc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_vld_r <= 1'b0;
      sc_vld_r <= 1'b0;
    end else begin
      sd_vld_r <= dist_vld;
      sc_vld_r <= sd_vld_r;
    end
    sd_r     <= $signed({1'b0, root_dist}) - $signed({4'b0000, radius_r});
    scaled_r <= sd_r * $signed({1'b0, m_eff});
  end

  // map -1..1 onto 0..255: ((s + 1.0) * 255) >> (F + 1), clamped
  logic signed [31:0] shifted;
  logic signed [39:0] tval;
  logic [7:0]         intensity_nxt;
  logic [7:0]         intensity_r;
  logic               out_vld_r;

  assign shifted = scaled_r + 32'sd65536;
  assign tval    = $signed({shifted, 8'h00}) - 40'(shifted);

  always_comb begin
    if (tval <= 40'sd0) begin
      intensity_nxt = 8'd0;
    end else if (tval[38:F+1] > 22'd255) begin
      intensity_nxt = 8'd255;
    end else begin
      intensity_nxt = tval[F+8:F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= sc_vld_r;
    end
    intensity_r <= intensity_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_intensity = intensity_r;

endmodule

[design/cdf_checker.sv]
// ----------------------------------------------------------------------------
// cdf_assert_checker
// Port-level checks on the pixel pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "circle_distance_field_pixel_assert.svh"

module cdf_assert_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  logic accept;
  assign accept = start && !busy;

  `CDF_ASSERT_ALWAYS(a_never_busy, !busy)
  `CDF_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)
  `CDF_ASSERT_IMPLY(a_out_has_source, out_valid, $past(accept, cdf_pkg::LATENCY))
  `CDF_ASSERT_IMPLY(a_accept_gives_out, $past(accept, cdf_pkg::LATENCY) && $past(rst_n, cdf_pkg::LATENCY), out_valid || !$stable(rst_n))

endmodule

bind circle_distance_field_pixel cdf_assert_checker u_cdf_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .cfg_ready(cfg_ready)
);
